FILE: hw/rtl/hbp_pkg.sv
// Shared constants, action codes and word types of the Huffman bit packer.
`default_nettype none

package hbp_pkg;

  // Table geometry
  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned TBL_AW       = $clog2(SYMBOL_COUNT);
  localparam int unsigned SYM_W        = 8;

  // Code word and length fields
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned MAX_CODE_LEN = 32;

  // Bit accumulator: up to seven carried bits plus one full code
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PEND_W       = BYTE_W - 1;
  localparam int unsigned ACC_W        = MAX_CODE_LEN + PEND_W;
  localparam int unsigned CNT_W        = $clog2(ACC_W + 1);

  // Command queue between front and packer
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  // Action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } hbp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              is_last;
  } hbp_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } hbp_entry_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } hbp_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hbp_front.sv
// Front end: code table, input word acceptance and command classification.
`default_nettype none

module hbp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire hbp_pkg::hbp_in_t in_data_i,
  output logic                  cmd_valid_o,
  output hbp_pkg::hbp_cmd_t     cmd_o,
  input  wire logic             cmd_full_i
);

  localparam int unsigned TblAw  = hbp_pkg::TBL_AW;
  localparam int unsigned SymW   = hbp_pkg::SYM_W;
  localparam int unsigned LenW   = hbp_pkg::LEN_W;

  hbp_pkg::hbp_entry_t code_mem [hbp_pkg::SYMBOL_COUNT];
  hbp_pkg::hbp_entry_t rd_q;

  logic             accept;
  logic             sym_ok;
  logic [TblAw-1:0] idx;
  logic [LenW-1:0]  len_sat;
  logic             is_load;
  logic             is_enc;
  logic             is_flush;
  logic             need_push;
  logic             stall;

  logic stg_valid_q, stg_valid_d;
  logic stg_flush_q, stg_flush_d;
  logic stg_ok_q, stg_ok_d;

  // Decode the incoming word
  assign idx      = in_data_i.symbol[TblAw-1:0];
  assign sym_ok   = {1'b0, in_data_i.symbol} < (SymW + 1)'(hbp_pkg::SYMBOL_COUNT);
  assign is_load  = in_data_i.action == hbp_pkg::ACT_LOAD;
  assign is_enc   = in_data_i.action == hbp_pkg::ACT_ENCODE;
  assign is_flush = in_data_i.action == hbp_pkg::ACT_FLUSH;
  assign len_sat  = (in_data_i.code_len > LenW'(hbp_pkg::MAX_CODE_LEN)) ?
                    LenW'(hbp_pkg::MAX_CODE_LEN) : in_data_i.code_len;

  // Hold the stage while its command cannot enter the queue
  assign need_push = stg_valid_q && (stg_flush_q || (stg_ok_q && (rd_q.code_len != '0)));
  assign stall     = need_push && cmd_full_i;
  assign full_o    = stall;
  assign accept    = push_i && !stall;

  // Write table entries on load, read them on encode
  always_ff @(posedge clk_i) begin
    if (accept && is_load && sym_ok) begin
      code_mem[idx] <= '{code_bits: in_data_i.code_bits, code_len: len_sat};
    end
    if (accept && is_enc) begin
      rd_q <= code_mem[idx];
    end
  end

  // Advance the classify stage
  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_flush_d = stg_flush_q;
    stg_ok_d    = stg_ok_q;
    if (!stall) begin
      stg_valid_d = push_i && (is_enc || is_flush);
      stg_flush_d = is_flush;
      stg_ok_d    = sym_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      stg_flush_q <= 1'b0;
      stg_ok_q    <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      stg_flush_q <= stg_flush_d;
      stg_ok_q    <= stg_ok_d;
    end
  end

  // Drop empty codes here; pass encodes and flushes on
  assign cmd_valid_o     = need_push;
  assign cmd_o.flush     = stg_flush_q;
  assign cmd_o.code_bits = rd_q.code_bits;
  assign cmd_o.code_len  = rd_q.code_len;

  a_load_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> !stg_valid_q)
    else $error("load word entered the classify stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (stg_valid_q && $stable(stg_flush_q)))
    else $error("stalled command left the stage");

endmodule

`default_nettype wire

FILE: hw/rtl/hbp_queue.sv
// Short command queue between the front end and the bit packer.
`default_nettype none

module hbp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire hbp_pkg::hbp_cmd_t wdata_i,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output hbp_pkg::hbp_cmd_t      rdata_o
);

  localparam int unsigned Depth = hbp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = hbp_pkg::QPTR_W;

  hbp_pkg::hbp_cmd_t slot_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == (PtrW + 1)'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  // Store the incoming command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW + 1)'(Depth))
    else $error("queue occupancy out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty command queue");

endmodule

`default_nettype wire

FILE: hw/rtl/hbp_packer.sv
// Back end: bit accumulator that packs codes MSB first and emits bytes.
`default_nettype none

module hbp_packer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire hbp_pkg::hbp_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output hbp_pkg::hbp_out_t      out_data_o
);

  localparam int unsigned AccW  = hbp_pkg::ACC_W;
  localparam int unsigned CntW  = hbp_pkg::CNT_W;
  localparam int unsigned PendW = hbp_pkg::PEND_W;
  localparam int unsigned ByteW = hbp_pkg::BYTE_W;
  localparam int unsigned CodeW = hbp_pkg::CODE_W;

  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   total_q, total_d;
  hbp_pkg::hbp_out_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              out_rdy;
  logic              has_byte;
  logic [CntW-1:0]   rem_cnt;
  logic              rem_small;
  logic [PendW-1:0]  pend_mask;
  logic [PendW-1:0]  rem_bits;
  logic [CodeW-1:0]  word_mask;
  logic [CodeW-1:0]  word;
  logic [AccW-1:0]   comp_acc;
  logic [CntW-1:0]   comp_total;
  logic [CntW-1:0]   byte_shift;
  logic [ByteW-1:0]  emit_val;
  logic [CntW-1:0]   pad_shift;
  logic [ByteW-1:0]  flush_val;
  logic              emit_byte;
  logic              take_enc;
  logic              take_flush;

  // Carve the next byte off the top of the accumulator
  assign out_rdy    = !out_valid_q || pop_i;
  assign has_byte   = total_q >= CntW'(ByteW);
  assign byte_shift = total_q - CntW'(ByteW);
  assign emit_val   = ByteW'(acc_q >> byte_shift);
  assign rem_cnt    = has_byte ? byte_shift : total_q;
  assign rem_small  = rem_cnt < CntW'(ByteW);

  // Keep the leftover bits, append the masked code word
  assign pend_mask  = ~({PendW{1'b1}} << rem_cnt);
  assign rem_bits   = acc_q[PendW-1:0] & pend_mask;
  assign word_mask  = ~({CodeW{1'b1}} << cmd_i.code_len);
  assign word       = cmd_i.code_bits & word_mask;
  assign comp_acc   = (AccW'(rem_bits) << cmd_i.code_len) | AccW'(word);
  assign comp_total = rem_cnt + CntW'(cmd_i.code_len);

  // Pad the partial byte with zeros on flush
  assign pad_shift  = CntW'(ByteW) - total_q;
  assign flush_val  = ByteW'(rem_bits) << pad_shift;

  // Emit a byte, merge the next code into what remains, or flush
  assign emit_byte  = has_byte && out_rdy;
  assign take_enc   = cmd_valid_i && !cmd_i.flush && rem_small && (!has_byte || emit_byte);
  assign take_flush = cmd_valid_i && cmd_i.flush && !has_byte && out_rdy;
  assign cmd_pop_o  = take_enc || take_flush;

  always_comb begin
    acc_d       = acc_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    priority if (take_enc) begin
      acc_d   = comp_acc;
      total_d = comp_total;
    end else if (emit_byte) begin
      total_d = byte_shift;
    end else if (take_flush) begin
      total_d = '0;
    end
    priority if (emit_byte) begin
      out_d       = '{data_byte: emit_val, byte_valid: 1'b1, is_last: 1'b0};
      out_valid_d = 1'b1;
    end else if (take_flush) begin
      out_d       = '{data_byte: flush_val, byte_valid: total_q != '0, is_last: 1'b1};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(AccW))
    else $error("bit count exceeds accumulator");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_flush |=> (total_q == '0 && out_valid_q && out_q.is_last))
    else $error("flush did not clear pending bits");

  a_single_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take_flush && (emit_byte || take_enc)))
    else $error("flush overlapped another packer action");

endmodule

`default_nettype wire

FILE: hw/rtl/huffman_bit_packer_top.sv
// Top level of the Huffman bit packer: front end, command queue, packer.
`default_nettype none

// Accepts one word per cycle while full is low: a table load, a symbol
// encode or a flush. The front end writes or reads the 256-entry code
// table in the accept cycle and classifies the word in the next cycle;
// encodes of zero-length codes, loads and unused actions stop there.
// Encodes and flushes pass a four-entry queue to the packer, which emits
// one output byte per cycle while the output register is free, and merges
// the next code into the leftover bits in the same cycle; a flush is
// taken once the bytes ahead of it have left. Input keeps one word per
// cycle as long as codes average eight bits or fewer and bytes are
// popped; longer bursts fill the queue and raise full. With an idle
// packer the first byte of an encode passes the table read and classify
// stage, the queue, the accumulator and the output register; a flush
// skips the accumulator. Table entries are undefined after reset until loaded.
module huffman_bit_packer_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire hbp_pkg::hbp_in_t in_data_i,
  output logic                  empty,
  input  wire logic             pop,
  output hbp_pkg::hbp_out_t     out_data_o
);

  logic              cmd_valid;
  logic              cmd_full;
  hbp_pkg::hbp_cmd_t cmd_in;
  hbp_pkg::hbp_cmd_t cmd_out;
  logic              cmd_empty;
  logic              cmd_pop;

  hbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  hbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .full_o  (cmd_full),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_out)
  );

  hbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
